FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the block clock, off while reset is asserted
`define JAQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition that must never be seen
`define JAQ_NEVER(name, cond, msg) \
  `JAQ_ASSERT(name, !(cond), msg)

`endif

FILE: src/jaq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jaq_pkg;

  // channel counts
  localparam int AXIS_COUNT   = 16;
  localparam int BUTTON_COUNT = 32;
  localparam int AXIS_AW      = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
  localparam int BUTTON_AW    = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

  // field widths
  localparam int CH_W      = 5;
  localparam int POS_W     = 16;
  localparam int TICK_W    = 16;
  localparam int TIMER_W   = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int GROUP_MAX = 3;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  // sample kinds
  localparam logic OP_BUTTON = 1'b0;
  localparam logic OP_AXIS   = 1'b1;

  // event kinds
  localparam logic [1:0] KIND_MOVE   = 2'd0;
  localparam logic [1:0] KIND_BUTTON = 2'd1;
  localparam logic [1:0] KIND_LOW    = 2'd2;
  localparam logic [1:0] KIND_HIGH   = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_TOL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LEVEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_DELAY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE     = 3'd5;

  // register reset values
  localparam logic [CFG_W-1:0]        MOVE_TOL_RST   = 16'd66;
  localparam logic signed [CFG_W-1:0] LOW_LEVEL_RST  = -16'sd29491;
  localparam logic signed [CFG_W-1:0] HIGH_LEVEL_RST = 16'sd29491;

  typedef struct packed {
    logic                    op;
    logic [CH_W-1:0]         channel;
    logic                    pressed_in;
    logic signed [POS_W-1:0] position;
    logic [TICK_W-1:0]       elapsed;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [CH_W-1:0]         channel_out;
    logic                    level;
    logic signed [POS_W-1:0] position_out;
    logic                    last;
  } out_item_t;

  // results of one sample, in order, with their count
  typedef struct packed {
    out_item_t [GROUP_MAX-1:0] item;
    logic [1:0]                cnt;
  } group_t;

  typedef struct packed {
    logic signed [POS_W-1:0] prev;
    logic [TIMER_W-1:0]      timer;
    logic                    low_held;
    logic                    high_held;
  } axis_entry_t;

  typedef struct packed {
    logic               held;
    logic [TIMER_W-1:0] timer;
  } button_entry_t;

  typedef struct packed {
    logic               fire;
    logic [TIMER_W-1:0] timer;
  } timer_res_t;

  // delay the timer waits for, from the current and the last state
  function automatic logic [TICK_W-1:0] pick_delay(logic now, logic prev_on,
                                                   logic [TICK_W-1:0] press,
                                                   logic [TICK_W-1:0] rep,
                                                   logic [TICK_W-1:0] rel);
    if (now) begin
      return prev_on ? rep : press;
    end
    return rel;
  endfunction

  // saturating advance (cleared while neither now nor before), fire and subtract
  function automatic timer_res_t run_timer(logic [TIMER_W-1:0] t, logic now,
                                           logic prev_on, logic [TICK_W-1:0] elapsed,
                                           logic [TICK_W-1:0] d);
    logic [TIMER_W:0]   sum;
    logic [TIMER_W-1:0] tv;
    timer_res_t         res;
    sum = {1'b0, t} + {2'b00, elapsed};
    if (now || prev_on) begin
      tv = sum[TIMER_W] ? TIMER_MAX : sum[TIMER_W-1:0];
    end else begin
      tv = '0;
    end
    res.fire  = (tv >= {1'b0, d});
    res.timer = res.fire ? (tv - {1'b0, d}) : tv;
    return res;
  endfunction

  function automatic out_item_t mk_item(logic [1:0] kind, logic [CH_W-1:0] ch,
                                        logic level, logic signed [POS_W-1:0] pos,
                                        logic last);
    out_item_t o;
    o.kind         = kind;
    o.channel_out  = ch;
    o.level        = level;
    o.position_out = pos;
    o.last         = last;
    return o;
  endfunction

endpackage

`default_nettype wire

FILE: src/jaq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module jaq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/jaq_outbuf.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module jaq_outbuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_valid_i,
  input  jaq_pkg::group_t    load_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jaq_pkg::out_item_t out_item_o
);
  import jaq_pkg::*;

  out_item_t [GROUP_MAX-1:0] item_q;
  logic [1:0]                cnt_q;
  logic [1:0]                idx_q;
  logic                      pop;
  logic                      last_pop;
  logic                      load;

  // hand out the stored results one per cycle while the receiver is ready
  assign pop      = (cnt_q != 2'd0) && out_ready_i;
  assign last_pop = pop && (idx_q == (cnt_q - 2'd1));
  assign free_o   = (cnt_q == 2'd0) || last_pop;
  assign load     = load_valid_i && free_o;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = item_q[idx_q];

  // count and read pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else if (load) begin
      cnt_q <= load_i.cnt;
      idx_q <= 2'd0;
    end else if (last_pop) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else if (pop) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  // result storage
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= load_i.item;
    end
  end

  `JAQ_ASSERT(a_idx_in_group, cnt_q != 2'd0 |-> idx_q < cnt_q, "read pointer past group")
  `JAQ_ASSERT(a_last_marks_end, out_valid_o |-> (out_item_o.last == (idx_q == (cnt_q - 2'd1))),
              "last flag not on final result of item")
  `JAQ_NEVER(a_no_overwrite, load_valid_i && free_o && out_valid_o && !last_pop,
             "group overwritten before drained")

endmodule

`default_nettype wire

FILE: src/joystick_autorepeat_qualifier.sv
// joystick_autorepeat_qualifier
// input channel in_*: one tick sample per item, a button pressed bit or an
// axis position (Q1.15) plus the ticks elapsed since that channel's last sample.
// output channel out_*: events (axis moved, button update, low/high virtual
// button); the final event caused by one sample carries last.
// cfg_*: plain register writes, taken in the cycle the write enable is high;
// write only while the block is idle.
// path: an accepted item enters the stage register as its channel state is
// read from memory; the update there loads the item's events into the result
// register that drives out_*. throughput: one item per cycle while each item
// gives at most one event and the receiver is ready; the result register
// hands out one event per ready cycle, so an item with two or three events
// holds back the next item with events until its last one is taken. per-channel
// state sits in two single-port-write RAMs read as the item is accepted; a
// bypass covers a write to the same channel by the item just in front.
// reset: all channels idle with zero timers at once (per-entry valid flops),
// registers at their defaults; no clearing pass.
// a stalled receiver fills the result register, the update stage then holds
// and in_ready_o falls; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module joystick_autorepeat_qualifier (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  jaq_pkg::in_item_t                 in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output jaq_pkg::out_item_t                out_item_o,
  input  logic                              cfg_we_i,
  input  logic [jaq_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [jaq_pkg::CFG_W-1:0]         cfg_data_i
);
  import jaq_pkg::*;

  // configuration registers
  logic [CFG_W-1:0]        move_tol_q;
  logic signed [CFG_W-1:0] low_level_q;
  logic signed [CFG_W-1:0] high_level_q;
  logic [CFG_W-1:0]        press_delay_q;
  logic [CFG_W-1:0]        repeat_q;
  logic [CFG_W-1:0]        release_q;

  // update stage
  logic              accept;
  logic              s1_valid_q;
  in_item_t          s1_q;
  logic              s1_adv;
  logic              grp_free;
  group_t            grp_d;

  // channel state
  logic [AXIS_COUNT-1:0]   avalid_q;
  logic [BUTTON_COUNT-1:0] bvalid_q;
  axis_entry_t             a_rdata;
  axis_entry_t             a_wdata;
  axis_entry_t             afwd_data_q;
  logic                    afwd_q;
  button_entry_t           b_rdata;
  button_entry_t           b_wdata;
  button_entry_t           bfwd_data_q;
  logic                    bfwd_q;
  logic                    a_we;
  logic                    b_we;
  logic [AXIS_AW-1:0]      a_idx;
  logic [BUTTON_AW-1:0]    b_idx;
  logic [AXIS_AW-1:0]      in_a_idx;
  logic [BUTTON_AW-1:0]    in_b_idx;

  // update datapath
  logic                    a_in_range;
  logic                    b_in_range;
  axis_entry_t             a_ent;
  button_entry_t           b_ent;
  logic signed [POS_W:0]   diff;
  logic [POS_W:0]          absd;
  logic                    mv;
  logic                    lo;
  logic                    hi;
  logic                    a_before;
  timer_res_t              a_tr;
  timer_res_t              b_tr;

  assign a_idx    = s1_q.channel[AXIS_AW-1:0];
  assign b_idx    = s1_q.channel[BUTTON_AW-1:0];
  assign in_a_idx = in_item_i.channel[AXIS_AW-1:0];
  assign in_b_idx = in_item_i.channel[BUTTON_AW-1:0];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_tol_q    <= MOVE_TOL_RST;
      low_level_q   <= LOW_LEVEL_RST;
      high_level_q  <= HIGH_LEVEL_RST;
      press_delay_q <= '0;
      repeat_q      <= '0;
      release_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MOVE_TOL:    move_tol_q    <= cfg_data_i;
        REG_LOW_LEVEL:   low_level_q   <= cfg_data_i;
        REG_HIGH_LEVEL:  high_level_q  <= cfg_data_i;
        REG_PRESS_DELAY: press_delay_q <= cfg_data_i;
        REG_REPEAT:      repeat_q      <= cfg_data_i;
        REG_RELEASE:     release_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input handshake: stage free or moving on
  assign accept     = in_valid_i && in_ready_o;
  assign s1_adv     = s1_valid_q && ((grp_d.cnt == 2'd0) || grp_free);
  assign in_ready_o = !s1_valid_q || s1_adv;

  // state memories, read as the item is accepted
  jaq_ram #(
    .WIDTH ($bits(axis_entry_t)),
    .DEPTH (AXIS_COUNT)
  ) u_axis_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_idx),
    .wdata_i (a_wdata),
    .re_i    (accept && (in_item_i.op == OP_AXIS)),
    .raddr_i (in_a_idx),
    .rdata_o (a_rdata)
  );

  jaq_ram #(
    .WIDTH ($bits(button_entry_t)),
    .DEPTH (BUTTON_COUNT)
  ) u_button_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_idx),
    .wdata_i (b_wdata),
    .re_i    (accept && (in_item_i.op == OP_BUTTON)),
    .raddr_i (in_b_idx),
    .rdata_o (b_rdata)
  );

  // stage register, valid bits and same-channel bypass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      avalid_q   <= '0;
      bvalid_q   <= '0;
      afwd_q     <= 1'b0;
      bfwd_q     <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        afwd_q     <= a_we && (a_idx == in_a_idx);
        bfwd_q     <= b_we && (b_idx == in_b_idx);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (a_we) begin
        avalid_q[a_idx] <= 1'b1;
      end
      if (b_we) begin
        bvalid_q[b_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q        <= in_item_i;
      afwd_data_q <= a_wdata;
      bfwd_data_q <= b_wdata;
    end
  end

  // read-modify-write of the sample's channel
  always_comb begin
    a_in_range = ({1'b0, s1_q.channel} < (CH_W + 1)'(AXIS_COUNT));
    b_in_range = ({1'b0, s1_q.channel} < (CH_W + 1)'(BUTTON_COUNT));

    // entry never written reads as idle
    a_ent = avalid_q[a_idx] ? (afwd_q ? afwd_data_q : a_rdata) : '0;
    b_ent = bvalid_q[b_idx] ? (bfwd_q ? bfwd_data_q : b_rdata) : '0;

    // axis move and thresholds
    diff     = {s1_q.position[POS_W-1], s1_q.position} - {a_ent.prev[POS_W-1], a_ent.prev};
    absd     = diff[POS_W] ? (POS_W + 1)'(-diff) : diff;
    mv       = !avalid_q[a_idx] || (absd > {1'b0, move_tol_q});
    lo       = s1_q.position < low_level_q;
    hi       = s1_q.position > high_level_q;
    a_before = a_ent.low_held || a_ent.high_held;
    a_tr     = run_timer(a_ent.timer, lo || hi, a_before, s1_q.elapsed,
                         pick_delay(lo || hi, a_before, press_delay_q, repeat_q, release_q));
    b_tr     = run_timer(b_ent.timer, s1_q.pressed_in, b_ent.held, s1_q.elapsed,
                         pick_delay(s1_q.pressed_in, b_ent.held, press_delay_q, repeat_q,
                                    release_q));

    a_wdata.prev      = mv ? s1_q.position : a_ent.prev;
    a_wdata.timer     = a_tr.timer;
    a_wdata.low_held  = a_tr.fire ? lo : a_ent.low_held;
    a_wdata.high_held = a_tr.fire ? hi : a_ent.high_held;
    b_wdata.held      = b_tr.fire ? s1_q.pressed_in : b_ent.held;
    b_wdata.timer     = b_tr.timer;

    a_we = s1_adv && (s1_q.op == OP_AXIS) && a_in_range;
    b_we = s1_adv && (s1_q.op == OP_BUTTON) && b_in_range;

    // events of this sample, in order
    grp_d = '0;
    if (s1_valid_q && (s1_q.op == OP_AXIS) && a_in_range) begin
      if (mv) begin
        grp_d.item[0] = mk_item(KIND_MOVE, s1_q.channel, 1'b0, s1_q.position, !a_tr.fire);
        if (a_tr.fire) begin
          grp_d.item[1] = mk_item(KIND_LOW, s1_q.channel, lo, s1_q.position, 1'b0);
          grp_d.item[2] = mk_item(KIND_HIGH, s1_q.channel, hi, s1_q.position, 1'b1);
          grp_d.cnt     = 2'd3;
        end else begin
          grp_d.cnt     = 2'd1;
        end
      end else if (a_tr.fire) begin
        grp_d.item[0] = mk_item(KIND_LOW, s1_q.channel, lo, s1_q.position, 1'b0);
        grp_d.item[1] = mk_item(KIND_HIGH, s1_q.channel, hi, s1_q.position, 1'b1);
        grp_d.cnt     = 2'd2;
      end
    end else if (s1_valid_q && (s1_q.op == OP_BUTTON) && b_in_range && b_tr.fire) begin
      grp_d.item[0] = mk_item(KIND_BUTTON, s1_q.channel, s1_q.pressed_in, '0, 1'b1);
      grp_d.cnt     = 2'd1;
    end
  end

  // result register
  jaq_outbuf u_outbuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (s1_valid_q && (grp_d.cnt != 2'd0)),
    .load_i       (grp_d),
    .free_o       (grp_free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

  `JAQ_ASSERT(a_stall_holds, s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_q),
              "stalled item lost or changed")
  `JAQ_ASSERT(a_write_on_advance, a_we || b_we |-> s1_adv, "state written without advance")
  `JAQ_NEVER(a_one_write, a_we && b_we, "both state memories written for one item")

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import jaq_pkg::*;

  // register indexes past the end of the map, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int PRINT_LIMIT   = 40;

  typedef struct packed {
    logic               fires;
    logic [TIMER_W-1:0] ticks;
  } tick_step_t;

  // predictor of the autorepeat qualifier plus the queue of events still due
  class autorepeat_scoreboard;
    logic [CFG_W-1:0]        move_tol;
    logic signed [POS_W-1:0] low_lvl;
    logic signed [POS_W-1:0] high_lvl;
    logic [CFG_W-1:0]        press_dly;
    logic [CFG_W-1:0]        repeat_dly;
    logic [CFG_W-1:0]        release_dly;

    logic signed [POS_W-1:0] axis_last_pos [AXIS_COUNT];
    bit                      axis_pos_known[AXIS_COUNT];
    bit                      low_on        [AXIS_COUNT];
    bit                      high_on       [AXIS_COUNT];
    logic [TIMER_W-1:0]      axis_ticks    [AXIS_COUNT];
    bit                      btn_on        [BUTTON_COUNT];
    logic [TIMER_W-1:0]      btn_ticks     [BUTTON_COUNT];

    out_item_t events_due[$];
    int        errors;
    int        checked;

    function new();
      move_tol    = MOVE_TOL_RST;
      low_lvl     = LOW_LEVEL_RST;
      high_lvl    = HIGH_LEVEL_RST;
      press_dly   = '0;
      repeat_dly  = '0;
      release_dly = '0;
      foreach (axis_last_pos[i]) begin
        axis_last_pos[i]  = '0;
        axis_pos_known[i] = 1'b0;
        low_on[i]         = 1'b0;
        high_on[i]        = 1'b0;
        axis_ticks[i]     = '0;
      end
      foreach (btn_on[i]) begin
        btn_on[i]    = 1'b0;
        btn_ticks[i] = '0;
      end
      errors  = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_MOVE_TOL:    move_tol    = data;
        REG_LOW_LEVEL:   low_lvl     = data;
        REG_HIGH_LEVEL:  high_lvl    = data;
        REG_PRESS_DELAY: press_dly   = data;
        REG_REPEAT:      repeat_dly  = data;
        REG_RELEASE:     release_dly = data;
        default: ;
      endcase
    endfunction

    // advance one channel timer by the elapsed ticks, fire once it reaches its delay
    function tick_step_t step_ticks(logic [TIMER_W-1:0] ticks, bit now, bit was_on,
                                    logic [TICK_W-1:0] elapsed);
      tick_step_t       r;
      logic [TIMER_W:0] sum;
      logic [CFG_W-1:0] wait_for;
      wait_for = now ? (was_on ? repeat_dly : press_dly) : release_dly;
      sum = {1'b0, ticks} + (TIMER_W+1)'(elapsed);
      if (now || was_on) begin
        r.ticks = sum[TIMER_W] ? {TIMER_W{1'b1}} : sum[TIMER_W-1:0];
      end else begin
        r.ticks = '0;
      end
      r.fires = (r.ticks >= TIMER_W'(wait_for));
      if (r.fires) begin
        r.ticks = r.ticks - TIMER_W'(wait_for);
      end
      return r;
    endfunction

    function out_item_t make_event(logic [1:0] kind, logic [CH_W-1:0] ch, bit level,
                                   logic signed [POS_W-1:0] pos);
      out_item_t e;
      e.kind         = kind;
      e.channel_out  = ch;
      e.level        = level;
      e.position_out = pos;
      e.last         = 1'b0;
      return e;
    endfunction

    // work out the events one accepted sample causes
    function void note_sample(in_item_t s);
      out_item_t               batch[$];
      tick_step_t              st;
      logic signed [POS_W-1:0] pos;
      int                      ch;
      int                      move_abs;
      bit                      lo;
      bit                      hi;
      ch  = int'(s.channel);
      pos = $signed(s.position);
      if (s.op == OP_BUTTON) begin
        if (ch >= BUTTON_COUNT) return;
        st = step_ticks(btn_ticks[ch], s.pressed_in, btn_on[ch], s.elapsed);
        btn_ticks[ch] = st.ticks;
        if (st.fires) begin
          batch.push_back(make_event(KIND_BUTTON, s.channel, s.pressed_in, '0));
          btn_on[ch] = s.pressed_in;
        end
      end else begin
        if (ch >= AXIS_COUNT) return;
        move_abs = int'(pos) - int'(axis_last_pos[ch]);
        if (move_abs < 0) move_abs = -move_abs;
        if (!axis_pos_known[ch] || move_abs > int'(move_tol)) begin
          batch.push_back(make_event(KIND_MOVE, s.channel, 1'b0, pos));
          axis_last_pos[ch]  = pos;
          axis_pos_known[ch] = 1'b1;
        end
        lo = (pos < low_lvl);
        hi = (pos > high_lvl);
        st = step_ticks(axis_ticks[ch], lo || hi, low_on[ch] || high_on[ch], s.elapsed);
        axis_ticks[ch] = st.ticks;
        if (st.fires) begin
          batch.push_back(make_event(KIND_LOW, s.channel, lo, pos));
          batch.push_back(make_event(KIND_HIGH, s.channel, hi, pos));
          low_on[ch]  = lo;
          high_on[ch] = hi;
        end
      end
      if (batch.size() > 0) begin
        batch[batch.size()-1].last = 1'b1;
      end
      foreach (batch[i]) events_due.push_back(batch[i]);
    endfunction

    function int pending();
      return events_due.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_LIMIT) begin
        $display("tb: mismatch at %0t: %s", $realtime, msg);
      end
    endtask

    task check_event(out_item_t got);
      out_item_t want;
      if (events_due.size() == 0) begin
        report($sformatf("unexpected event kind %0d ch %0d level %0d pos %0d last %0d",
                         got.kind, got.channel_out, got.level,
                         $signed(got.position_out), got.last));
        return;
      end
      want = events_due.pop_front();
      checked++;
      if (got.kind !== want.kind || got.channel_out !== want.channel_out ||
          got.level !== want.level || got.position_out !== want.position_out ||
          got.last !== want.last) begin
        report($sformatf("event %0d got %0d/%0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d/%0d",
                         checked, got.kind, got.channel_out, got.level,
                         $signed(got.position_out), got.last, want.kind,
                         want.channel_out, want.level, $signed(want.position_out),
                         want.last));
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni   = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_item  = '0;
  logic                 out_valid_o;
  logic                 out_ready = 1'b0;
  out_item_t            out_item_o;
  logic                 cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx  = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  autorepeat_scoreboard sb = new();
  bit in_idle_off  = 1'b0;
  bit out_idle_off = 1'b0;
  int last_pos     = 0;

  joystick_autorepeat_qualifier u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // hard stop
  initial begin
    #(2_000_000);
    $display("tb: done, errors");
    $finish;
  end

  // event sink with random stalls
  initial begin : event_sink
    int stall;
    forever begin
      stall = out_idle_off ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do begin
        @(posedge clk_i);
      end while (!(out_valid_o === 1'b1 && out_ready));
      sb.check_event(out_item_o);
    end
  end

  // one sample item, after a random gap, held until taken
  task drive_sample(in_item_t s);
    int gap;
    gap = in_idle_off ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= s;
    do begin
      @(posedge clk_i);
    end while (in_ready_o !== 1'b1);
    sb.note_sample(s);
  endtask

  task feed(bit op, int ch, bit pr, int pos, int el);
    in_item_t s;
    s.op         = op;
    s.channel    = CH_W'(ch);
    s.pressed_in = pr;
    s.position   = POS_W'(pos);
    s.elapsed    = TICK_W'(el);
    drive_sample(s);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // full register set, plus the two unmapped indexes
  task load_settings(int tol, int lo, int hi, int pr, int rp, int rl);
    write_reg(REG_MOVE_TOL, CFG_W'(tol));
    write_reg(REG_SPARE_A, CFG_W'($urandom_range(0, 65535)));
    write_reg(REG_LOW_LEVEL, CFG_W'(lo));
    write_reg(REG_HIGH_LEVEL, CFG_W'(hi));
    write_reg(REG_PRESS_DELAY, CFG_W'(pr));
    write_reg(REG_REPEAT, CFG_W'(rp));
    write_reg(REG_SPARE_B, CFG_W'($urandom_range(0, 65535)));
    write_reg(REG_RELEASE, CFG_W'(rl));
    cfg_we <= 1'b0;
  endtask

  // hold the sender until every event is out and the pipe is empty
  task settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function int clamp_q15(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // positions near the thresholds, the tolerance edge and the extremes, plus random ones
  function logic signed [POS_W-1:0] pick_position(bit want_press);
    int lo;
    int hi;
    int p;
    lo = int'(sb.low_lvl);
    hi = int'(sb.high_lvl);
    case ($urandom_range(0, 5))
      0: p = lo + int'($urandom_range(0, 4)) - 2;
      1: p = hi + int'($urandom_range(0, 4)) - 2;
      2: p = $urandom_range(0, 1) ? -32768 : 32767;
      3: begin
        p = int'(sb.move_tol) + int'($urandom_range(0, 2)) - 1;
        p = $urandom_range(0, 1) ? last_pos + p : last_pos - p;
      end
      4: p = int'($urandom_range(0, 65535)) - 32768;
      default: begin
        if (want_press) begin
          p = $urandom_range(0, 1) ? lo - int'($urandom_range(1, 3000))
                                   : hi + int'($urandom_range(1, 3000));
        end else begin
          p = (lo + hi) / 2 + int'($urandom_range(0, 100)) - 50;
        end
      end
    endcase
    last_pos = clamp_q15(p);
    return POS_W'(last_pos);
  endfunction

  // elapsed ticks scaled to the delays in force, with the odd full-range value
  function logic [TICK_W-1:0] pick_elapsed();
    int span;
    int r;
    span = int'(sb.press_dly);
    if (int'(sb.repeat_dly) > span) span = int'(sb.repeat_dly);
    if (int'(sb.release_dly) > span) span = int'(sb.release_dly);
    span = span + span / 2 + 1;
    if (span > 65535) span = 65535;
    r = $urandom_range(0, 9);
    if (r < 6) return TICK_W'($urandom_range(0, span));
    if (r < 8) return TICK_W'($urandom_range(0, 3));
    return TICK_W'($urandom_range(0, 65535));
  endfunction

  // press-and-release runs on a few channels, some runs pure noise
  task run_traffic(int target);
    in_item_t s;
    int       counted;
    int       len_on;
    int       len_off;
    int       r;
    int       ch;
    bit       op;
    bit       noise;
    counted = 0;
    while (counted < target) begin
      op = $urandom_range(0, 1);
      r  = $urandom_range(0, 9);
      if (r < 6) begin
        ch = $urandom_range(0, 3);
      end else if (r < 9) begin
        ch = op ? $urandom_range(0, AXIS_COUNT - 1) : $urandom_range(0, BUTTON_COUNT - 1);
      end else begin
        ch = $urandom_range(0, 31);
      end
      noise   = ($urandom_range(0, 5) == 0);
      len_on  = $urandom_range(0, 5);
      len_off = $urandom_range(1, 3);
      for (int i = 0; i < len_on + len_off; i++) begin
        s.op         = op;
        s.channel    = CH_W'(ch);
        s.pressed_in = noise ? 1'($urandom_range(0, 1)) : (i < len_on);
        s.position   = noise ? POS_W'($urandom_range(0, 65535)) : pick_position(i < len_on);
        s.elapsed    = pick_elapsed();
        drive_sample(s);
        if (op == OP_BUTTON || ch < AXIS_COUNT) counted++;
      end
      if ($urandom_range(0, 24) == 0) settle();
    end
  endtask

  // main sequence
  initial begin : stimulus
    int waited;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, every delay zero so each sample fires
    feed(OP_BUTTON, 0, 1'b1, 0, 0);
    feed(OP_BUTTON, 0, 1'b1, 0, 0);
    feed(OP_BUTTON, 0, 1'b0, 0, 0);
    // idle button still fires a release update
    feed(OP_BUTTON, 31, 1'b0, -1, 65535);
    // held button timer runs into saturation
    feed(OP_BUTTON, 31, 1'b1, 32767, 65535);
    feed(OP_BUTTON, 31, 1'b1, -32768, 65535);
    feed(OP_BUTTON, 31, 1'b1, 0, 65535);
    // first axis sample always moves, then the tolerance edge
    feed(OP_AXIS, 0, 1'b0, 0, 0);
    feed(OP_AXIS, 0, 1'b1, 66, 1);
    feed(OP_AXIS, 0, 1'b0, 67, 0);
    // thresholds: equal is not pressed, one past is
    feed(OP_AXIS, 0, 1'b0, -29491, 3);
    feed(OP_AXIS, 0, 1'b0, -29492, 0);
    feed(OP_AXIS, 15, 1'b0, 32767, 65535);
    feed(OP_AXIS, 15, 1'b0, 29491, 0);
    feed(OP_AXIS, 15, 1'b0, 29492, 1);
    feed(OP_AXIS, 15, 1'b1, -32768, 65535);
    // axis channels past the axis count are dropped
    feed(OP_AXIS, 16, 1'b1, 100, 5);
    feed(OP_AXIS, 31, 1'b0, -32768, 65535);
    feed(OP_AXIS, 3, 1'b1, -1, 16'h5555);
    feed(OP_BUTTON, 16, 1'b0, 0, 16'haaaa);
    settle();

    // moderate delays, pause for a full drain halfway
    load_settings(66, -29491, 29491, 3, 2, 4);
    run_traffic(35);
    settle();
    run_traffic(35);
    settle();

    // lowest tolerance and widest thresholds, no idling either side
    in_idle_off  = 1'b1;
    out_idle_off = 1'b1;
    load_settings(0, -32768, 32767, 0, 0, 0);
    run_traffic(60);
    settle();

    // top of every register but the high level, which takes its lowest value
    in_idle_off  = 1'b0;
    out_idle_off = 1'b0;
    load_settings(65535, 32767, -32768, 65535, 65535, 65535);
    run_traffic(60);
    settle();

    in_idle_off = 1'b1;
    load_settings(1, -16384, 16384, 0, 7, 0);
    run_traffic(60);
    settle();

    in_idle_off  = 1'b0;
    out_idle_off = 1'b1;
    load_settings($urandom_range(0, 65535), int'($urandom_range(0, 65535)) - 32768,
                  int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
    run_traffic(60);
    settle();

    out_idle_off = 1'b0;
    load_settings($urandom_range(0, 200), -int'($urandom_range(0, 32768)),
                  $urandom_range(0, 32767), $urandom_range(0, 20),
                  $urandom_range(0, 20), $urandom_range(0, 20));
    run_traffic(60);
    settle();

    load_settings(66, -29491, 29491, 1, 0, 2);
    run_traffic(50);

    // drain and close
    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d events never arrived", sb.pending()));
    end
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/jaq_pkg.sv
src/jaq_ram.sv
src/jaq_outbuf.sv
src/joystick_autorepeat_qualifier.sv
tb/sv/tb.sv
